[design/cbie_pkg.sv]
// Shared types, constants and the CBOR head builder for the item head encoder.
// No dependencies; every other design file refers to this package by scoped names.
package cbie_pkg;

   // Field and storage widths
   localparam int CAP_WIDTH         = 16;
   localparam int OFFSET_WIDTH      = 16;
   localparam int POS_WIDTH_DEFAULT = 16;
   localparam int MAX_BYTES         = 9;
   localparam int COUNT_WIDTH       = $clog2(MAX_BYTES + 1);

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd2048;

   // Command codes
   localparam logic [3:0] CMD_START     = 4'd0;
   localparam logic [3:0] CMD_UINT      = 4'd1;
   localparam logic [3:0] CMD_SINT      = 4'd2;
   localparam logic [3:0] CMD_MAP       = 4'd3;
   localparam logic [3:0] CMD_ARRAY     = 4'd4;
   localparam logic [3:0] CMD_TEXT_HEAD = 4'd5;
   localparam logic [3:0] CMD_TEXT_BYTE = 4'd6;
   localparam logic [3:0] CMD_BOOL      = 4'd7;
   localparam logic [3:0] CMD_DOUBLE    = 4'd8;

   // CBOR major types
   localparam logic [2:0] MAJOR_UINT  = 3'd0;
   localparam logic [2:0] MAJOR_NINT  = 3'd1;
   localparam logic [2:0] MAJOR_TEXT  = 3'd3;
   localparam logic [2:0] MAJOR_ARRAY = 3'd4;
   localparam logic [2:0] MAJOR_MAP   = 3'd5;

   // Additional info codes and simple values
   localparam logic [63:0] INLINE_MAX = 64'd23;
   localparam logic [4:0]  INFO_U8    = 5'd24;
   localparam logic [4:0]  INFO_U16   = 5'd25;
   localparam logic [4:0]  INFO_U32   = 5'd26;
   localparam logic [4:0]  INFO_U64   = 5'd27;
   localparam logic [7:0]  BYTE_TRUE  = 8'hF5;
   localparam logic [7:0]  BYTE_FALSE = 8'hF4;
   localparam logic [7:0]  BYTE_DOUBLE = 8'hFB;

   typedef struct packed {
      logic [3:0]  command;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0]              out_byte;
      logic [OFFSET_WIDTH-1:0] byte_offset;
      logic                    byte_valid;
      logic                    encode_ok;
      logic                    last;
   } rsp_type;

   // How the emitter treats a decoded word
   typedef enum logic [2:0] {
      KIND_STATUS,
      KIND_START,
      KIND_BYTES,
      KIND_TEXT_HEAD,
      KIND_TEXT_BYTE
   } kind_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]         count;
      logic [MAX_BYTES-1:0][7:0]      bytes;
   } head_type;

   // Decoded word: byte string in emission order (entry 0 first)
   typedef struct packed {
      kind_type                       kind;
      logic [COUNT_WIDTH-1:0]         count;
      logic [MAX_BYTES-1:0][7:0]      bytes;
      logic [63:0]                    value;
   } frame_type;

   // Build a head with the shortest argument form
   function automatic head_type make_head(input logic [2:0] major, input logic [63:0] arg);
      head_type h;
      h.bytes = '0;
      h.count = COUNT_WIDTH'(1);
      if (arg <= INLINE_MAX) begin
         h.bytes[0] = {major, arg[4:0]};
      end else if (arg <= 64'h0000_0000_0000_00FF) begin
         h.bytes[0] = {major, INFO_U8};
         h.bytes[1] = arg[7:0];
         h.count    = COUNT_WIDTH'(2);
      end else if (arg <= 64'h0000_0000_0000_FFFF) begin
         h.bytes[0] = {major, INFO_U16};
         h.bytes[1] = arg[15:8];
         h.bytes[2] = arg[7:0];
         h.count    = COUNT_WIDTH'(3);
      end else if (arg <= 64'h0000_0000_FFFF_FFFF) begin
         h.bytes[0] = {major, INFO_U32};
         h.bytes[1] = arg[31:24];
         h.bytes[2] = arg[23:16];
         h.bytes[3] = arg[15:8];
         h.bytes[4] = arg[7:0];
         h.count    = COUNT_WIDTH'(5);
      end else begin
         h.bytes[0] = {major, INFO_U64};
         h.bytes[1] = arg[63:56];
         h.bytes[2] = arg[55:48];
         h.bytes[3] = arg[47:40];
         h.bytes[4] = arg[39:32];
         h.bytes[5] = arg[31:24];
         h.bytes[6] = arg[23:16];
         h.bytes[7] = arg[15:8];
         h.bytes[8] = arg[7:0];
         h.count    = COUNT_WIDTH'(9);
      end
      return h;
   endfunction

endpackage

[design/cbie_decode.sv]
// Command decoder: turns one request word into the byte string it encodes.
// Depends on cbie_pkg (types, command codes, head builder).
module cbie_decode (
   input  cbie_pkg::req_type   req,
   output cbie_pkg::frame_type frame
);

   cbie_pkg::head_type head;

   always_comb begin
      head        = cbie_pkg::make_head(cbie_pkg::MAJOR_UINT, req.value);
      frame.kind  = cbie_pkg::KIND_STATUS;
      frame.count = cbie_pkg::COUNT_WIDTH'(1);
      frame.bytes = '0;
      frame.value = req.value;
      case (req.command)
         cbie_pkg::CMD_START: begin
            frame.kind = cbie_pkg::KIND_START;
         end
         cbie_pkg::CMD_UINT: begin
            head = cbie_pkg::make_head(cbie_pkg::MAJOR_UINT, req.value);
            frame.kind  = cbie_pkg::KIND_BYTES;
            frame.count = head.count;
            frame.bytes = head.bytes;
         end
         cbie_pkg::CMD_SINT: begin
            // negative: major 1 carrying minus-one-minus-value
            if (req.value[63]) begin
               head = cbie_pkg::make_head(cbie_pkg::MAJOR_NINT, ~req.value);
            end else begin
               head = cbie_pkg::make_head(cbie_pkg::MAJOR_UINT, req.value);
            end
            frame.kind  = cbie_pkg::KIND_BYTES;
            frame.count = head.count;
            frame.bytes = head.bytes;
         end
         cbie_pkg::CMD_MAP: begin
            head = cbie_pkg::make_head(cbie_pkg::MAJOR_MAP, req.value);
            frame.kind  = cbie_pkg::KIND_BYTES;
            frame.count = head.count;
            frame.bytes = head.bytes;
         end
         cbie_pkg::CMD_ARRAY: begin
            head = cbie_pkg::make_head(cbie_pkg::MAJOR_ARRAY, req.value);
            frame.kind  = cbie_pkg::KIND_BYTES;
            frame.count = head.count;
            frame.bytes = head.bytes;
         end
         cbie_pkg::CMD_TEXT_HEAD: begin
            head = cbie_pkg::make_head(cbie_pkg::MAJOR_TEXT, req.value);
            frame.kind  = cbie_pkg::KIND_TEXT_HEAD;
            frame.count = head.count;
            frame.bytes = head.bytes;
         end
         cbie_pkg::CMD_TEXT_BYTE: begin
            frame.kind     = cbie_pkg::KIND_TEXT_BYTE;
            frame.bytes[0] = req.value[7:0];
         end
         cbie_pkg::CMD_BOOL: begin
            frame.kind     = cbie_pkg::KIND_BYTES;
            frame.bytes[0] = (req.value != 64'd0) ? cbie_pkg::BYTE_TRUE
                                                  : cbie_pkg::BYTE_FALSE;
         end
         cbie_pkg::CMD_DOUBLE: begin
            // 0xFB then the raw bits, big-endian
            frame.kind     = cbie_pkg::KIND_BYTES;
            frame.count    = cbie_pkg::COUNT_WIDTH'(9);
            frame.bytes[0] = cbie_pkg::BYTE_DOUBLE;
            frame.bytes[1] = req.value[63:56];
            frame.bytes[2] = req.value[55:48];
            frame.bytes[3] = req.value[47:40];
            frame.bytes[4] = req.value[39:32];
            frame.bytes[5] = req.value[31:24];
            frame.bytes[6] = req.value[23:16];
            frame.bytes[7] = req.value[15:8];
            frame.bytes[8] = req.value[7:0];
         end
         default: begin
            frame.kind = cbie_pkg::KIND_STATUS;
         end
      endcase
   end

endmodule

[design/cbie_emitter.sv]
// Byte emitter: holds one decoded word, writes its bytes into the bounded buffer
// one per free cycle, tracks size, ok flag, pending text. Depends on cbie_pkg.
module cbie_emitter #(
   parameter int POS_WIDTH = cbie_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cbie_pkg::CAP_WIDTH-1:0]    capacity,
   input  logic                              frame_valid,
   input  cbie_pkg::frame_type               frame,
   output logic                              frame_stall,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cbie_pkg::rsp_type                 rsp_data
);

   localparam int CMP_WIDTH = (POS_WIDTH > cbie_pkg::CAP_WIDTH) ? POS_WIDTH
                                                                : cbie_pkg::CAP_WIDTH;

   // input register
   logic                               frame_valid_ff;
   cbie_pkg::frame_type                frame_ff;
   logic [cbie_pkg::COUNT_WIDTH-1:0]   idx_ff, idx_in;

   // encoder state
   logic [POS_WIDTH-1:0] wp_ff, wp_in;
   logic                 ok_ff, ok_in;
   logic [63:0]          rem_ff, rem_in;
   logic                 drop_ff, drop_in;

   // result register
   logic                 rsp_valid_ff;
   cbie_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 out_free, advance, is_last, item_done, accept;
   logic                 do_write, write_fail;
   logic [7:0]           wr_byte;
   logic [CMP_WIDTH-1:0] wp_ext, wp_in_ext, cap_ext, room;

   // step control
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = frame_valid_ff && out_free;
      if (frame_ff.kind == cbie_pkg::KIND_BYTES || frame_ff.kind == cbie_pkg::KIND_TEXT_HEAD) begin
         is_last = (idx_ff == frame_ff.count - cbie_pkg::COUNT_WIDTH'(1));
      end else begin
         is_last = 1'b1;
      end
      item_done   = advance && is_last;
      frame_stall = frame_valid_ff && !item_done;
      accept      = frame_valid && !frame_stall;
      idx_in      = accept ? '0 : (advance ? idx_ff + cbie_pkg::COUNT_WIDTH'(1) : idx_ff);
   end

   assign wp_ext  = CMP_WIDTH'(wp_ff);
   assign cap_ext = CMP_WIDTH'(capacity);

   // compute one result and the state it leaves
   always_comb begin
      wp_in    = wp_ff;
      ok_in    = ok_ff;
      rem_in   = rem_ff;
      drop_in  = drop_ff;
      do_write = 1'b0;
      wr_byte  = frame_ff.bytes[idx_ff];

      rsp_in.out_byte    = 8'd0;
      rsp_in.byte_offset = wp_ext[cbie_pkg::OFFSET_WIDTH-1:0];
      rsp_in.byte_valid  = 1'b0;
      rsp_in.encode_ok   = ok_ff;
      rsp_in.last        = is_last;

      write_fail = (wp_ext >= cap_ext);

      case (frame_ff.kind)
         cbie_pkg::KIND_START: begin
            wp_in              = '0;
            ok_in              = 1'b1;
            rem_in             = 64'd0;
            drop_in            = 1'b0;
            rsp_in.byte_offset = '0;
            rsp_in.encode_ok   = 1'b1;
         end
         cbie_pkg::KIND_BYTES, cbie_pkg::KIND_TEXT_HEAD: begin
            // any encoded item cancels pending text
            do_write = 1'b1;
            if (idx_ff == '0) begin
               rem_in  = 64'd0;
               drop_in = 1'b0;
            end
         end
         cbie_pkg::KIND_TEXT_BYTE: begin
            if (rem_ff != 64'd0) begin
               rem_in   = rem_ff - 64'd1;
               do_write = !drop_ff;
               if (rem_ff == 64'd1) begin
                  drop_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      // bounded write of one byte
      if (do_write) begin
         if (write_fail) begin
            ok_in            = 1'b0;
            rsp_in.encode_ok = 1'b0;
         end else begin
            rsp_in.out_byte   = wr_byte;
            rsp_in.byte_valid = 1'b1;
            wp_in             = wp_ff + POS_WIDTH'(1);
         end
      end

      // text head: accept or drop the whole string after its head
      wp_in_ext = CMP_WIDTH'(wp_in);
      room      = (wp_in_ext < cap_ext) ? (cap_ext - wp_in_ext) : '0;
      if (frame_ff.kind == cbie_pkg::KIND_TEXT_HEAD && is_last) begin
         rem_in = frame_ff.value;
         if (frame_ff.value > 64'(room)) begin
            ok_in            = 1'b0;
            drop_in          = 1'b1;
            rsp_in.encode_ok = 1'b0;
         end else begin
            drop_in = 1'b0;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         wp_ff          <= '0;
         ok_ff          <= 1'b1;
         rem_ff         <= 64'd0;
         drop_ff        <= 1'b0;
      end else begin
         if (accept) begin
            frame_valid_ff <= 1'b1;
         end else if (item_done) begin
            frame_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            wp_ff        <= wp_in;
            ok_ff        <= ok_in;
            rem_ff       <= rem_in;
            drop_ff      <= drop_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         frame_ff <= frame;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/cbor_item_head_encoder.sv]
// CBOR item head encoder. Each request word is a command (start, uint, sint, map,
// array, text head, text byte, bool, double) that is decoded into its CBOR bytes
// and written into a bounded buffer, one response word per byte (or one status
// word when no byte is attempted), the final word of a command marked by last.
// The number of response words per command on the byte-wide response channel is
// one for start, text byte, bool, unknown codes and small heads, and up to nine
// for a double or a 64-bit argument. The next command is decoded and registered
// while the current one drains and is taken as its last word is issued, so
// consecutive commands follow with no gap unless rsp_stall holds the output.
// The capacity register (reset 2048) may be written only while the block is idle.
// Depends on cbie_pkg, cbie_decode and cbie_emitter.
module cbor_item_head_encoder #(
   parameter int POS_WIDTH = cbie_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cbie_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cbie_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_enable,
   input  logic [cbie_pkg::CAP_WIDTH-1:0] csr_write_data
);

   logic [cbie_pkg::CAP_WIDTH-1:0] capacity_ff;
   cbie_pkg::frame_type            frame;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= cbie_pkg::CAP_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   cbie_decode u_decode (
      .req   (req_data),
      .frame (frame)
   );

   cbie_emitter #(
      .POS_WIDTH (POS_WIDTH)
   ) u_emitter (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .frame_valid (req_valid),
      .frame       (frame),
      .frame_stall (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
